// ===== design/sms_pkg.sv =====
// Shared types and constants for the servo motion sequencer.
// Used by sms_front, sms_back and servo_motion_sequencer_top; depends on nothing.
package sms_pkg;

    // Command codes carried in the command field.
    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_MOVE  = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MIN_POS     = 2'd0;
    localparam logic [1:0] CFG_MAX_POS     = 2'd1;
    localparam logic [1:0] CFG_LOOP_ENABLE = 2'd2;
    localparam logic [1:0] CFG_MIN_DELAY   = 2'd3;

    localparam logic [7:0]  RST_MIN_POS   = 8'd0;
    localparam logic [7:0]  RST_MAX_POS   = 8'd180;
    localparam logic [15:0] RST_MIN_DELAY = 16'd0;

    // Queue between the front and back parts.
    localparam int          Q_DEPTH = 4;
    localparam int          Q_AW    = 2;
    localparam int          Q_CW    = 3;
    localparam logic [Q_CW-1:0] Q_FULL = 3'd4;

    typedef enum logic [2:0] {
        ST_STANDBY = 3'd0,
        ST_INIT    = 3'd1,
        ST_ACTION  = 3'd2,
        ST_HALT    = 3'd3,
        ST_ERROR   = 3'd4
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  target_pos;
        logic [15:0] step_delay;
        logic [31:0] now;
    } in_item_t;

    typedef struct packed {
        logic [2:0] machine_state;
        logic [7:0] position;
        logic [7:0] running_action;
        logic [7:0] action_total;
    } out_item_t;

    // Command after classification by the front part.
    typedef struct packed {
        logic        is_begin;
        logic        is_move;
        logic        is_reset;
        logic [7:0]  target_pos;
        logic [15:0] step_delay;
        logic [31:0] now;
    } q_item_t;

    typedef struct packed {
        logic [7:0]  min_pos;
        logic [7:0]  max_pos;
        logic        loop_enable;
        logic [15:0] min_delay;
    } cfg_t;

endpackage

// ===== design/sms_front.sv =====
// Front part: accepts commands, classifies them and holds them in a short queue.
// Depends on sms_pkg.
module sms_front
    import sms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     q_valid,
    input  logic     q_pop,
    output q_item_t  q_item
);

    q_item_t         queue_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_CW-1:0] count_reg;
    logic [Q_CW-1:0] count_next;
    logic            push;
    logic            pop;
    q_item_t         classified;

    always_comb
    begin
        classified.is_begin   = (in_data.command == CMD_BEGIN);
        classified.is_move    = (in_data.command == CMD_MOVE);
        classified.is_reset   = (in_data.command == CMD_RESET);
        classified.target_pos = in_data.target_pos;
        classified.step_delay = in_data.step_delay;
        classified.now        = in_data.now;
    end

    assign in_stall = (count_reg == Q_FULL);
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/sms_back.sv =====
// Back part: runs the sequencer state machine on queued commands and
// holds the result register. Depends on sms_pkg.
module sms_back
    import sms_pkg::*;
#(
    parameter int MAX_ACTIONS = 255,
    parameter int TIMER_BITS  = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    output logic      q_pop,
    input  q_item_t   q_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam logic [7:0] COUNT_CAP = (MAX_ACTIONS < 255) ? 8'(MAX_ACTIONS) : 8'd255;
    localparam int         CW        = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    fsm_state_t            state_reg;
    fsm_state_t            state_next;
    logic [7:0]            pos_reg;
    logic [7:0]            pos_next;
    logic [TIMER_BITS-1:0] last_reg;
    logic [TIMER_BITS-1:0] last_next;
    logic [7:0]            call_reg;
    logic [7:0]            call_next;
    logic [7:0]            active_reg;
    logic [7:0]            active_next;
    logic [7:0]            count_reg;
    logic [7:0]            count_next;
    logic                  out_valid_reg;
    out_item_t             out_reg;
    out_item_t             result;

    logic                  pop;
    logic                  turn;
    logic                  at_target;
    logic [7:0]            adv;
    logic                  list_done;
    logic [15:0]           held_delay;
    logic [TIMER_BITS-1:0] now_t;
    logic [TIMER_BITS-1:0] elapsed;
    logic                  step_due;
    logic [7:0]            stepped;
    logic [7:0]            clamped;

    generate
        if (TIMER_BITS <= 32)
        begin : g_now_narrow
            assign now_t = q_item.now[TIMER_BITS-1:0];
        end
        else
        begin : g_now_wide
            assign now_t = TIMER_BITS'(q_item.now);
        end
    endgenerate

    assign pop       = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop     = pop;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Shared decode of the queued command against the current state.
    always_comb
    begin
        turn       = q_item.is_move && (state_reg == ST_ACTION) && (active_reg == call_reg);
        at_target  = (pos_reg == q_item.target_pos);
        adv        = (active_reg != 8'hFF) ? active_reg + 8'd1 : active_reg;
        list_done  = (adv >= count_reg);
        held_delay = (q_item.step_delay < cfg.min_delay) ? cfg.min_delay : q_item.step_delay;
        elapsed    = now_t - last_reg;
        step_due   = (CW'(elapsed) >= CW'(held_delay));
        stepped    = (pos_reg < q_item.target_pos) ? pos_reg + 8'd1 : pos_reg - 8'd1;
        if (stepped < cfg.min_pos)
        begin
            clamped = cfg.min_pos;
        end
        else if (stepped > cfg.max_pos)
        begin
            clamped = cfg.max_pos;
        end
        else
        begin
            clamped = stepped;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (q_item.is_begin)
        begin
            case (state_reg)
                ST_STANDBY: state_next = ST_INIT;
                ST_INIT:    state_next = (count_reg == 8'd0) ? ST_ERROR : ST_ACTION;
                default:    state_next = state_reg;
            endcase
        end
        else if (turn && at_target)
        begin
            if (!list_done)
            begin
                state_next = ST_ACTION;
            end
            else if (cfg.loop_enable)
            begin
                state_next = (count_reg == 8'd0) ? ST_ERROR : ST_ACTION;
            end
            else
            begin
                state_next = ST_HALT;
            end
        end
        else if (q_item.is_reset && (state_reg == ST_HALT))
        begin
            state_next = ST_STANDBY;
        end
    end

    // Counters, position and result.
    always_comb
    begin
        call_next   = call_reg;
        count_next  = count_reg;
        active_next = active_reg;
        pos_next    = pos_reg;
        last_next   = last_reg;

        if (q_item.is_begin)
        begin
            call_next = 8'd0;
            if ((state_reg == ST_INIT) && (count_reg != 8'd0))
            begin
                active_next = 8'd0;
            end
        end

        if (q_item.is_move)
        begin
            call_next = (call_reg != 8'hFF) ? call_reg + 8'd1 : call_reg;
            if ((state_reg == ST_INIT) && (count_reg < COUNT_CAP))
            begin
                count_next = count_reg + 8'd1;
            end
            if (turn && at_target)
            begin
                active_next = adv;
                if (list_done && cfg.loop_enable && (count_reg != 8'd0))
                begin
                    active_next = 8'd0;
                end
            end
            else if (turn && step_due)
            begin
                pos_next  = clamped;
                last_next = now_t;
            end
        end

        if (q_item.is_reset && (state_reg == ST_HALT))
        begin
            active_next = 8'd0;
            count_next  = 8'd0;
        end

        result.machine_state  = state_next;
        result.position       = pos_next;
        result.running_action = active_next;
        result.action_total   = count_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_STANDBY;
            pos_reg       <= '0;
            last_reg      <= '0;
            call_reg      <= '0;
            active_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg  <= state_next;
                pos_reg    <= pos_next;
                last_reg   <= last_next;
                call_reg   <= call_next;
                active_reg <= active_next;
                count_reg  <= count_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/servo_motion_sequencer_top.sv =====
// Top level of the servo motion sequencer: configuration registers, front and back parts.
// Depends on sms_pkg, sms_front and sms_back.
//
//  Channel   Signals                        Carries
//  --------  -----------------------------  -----------------------------------------
//  input     in_valid, in_stall, in_data    one command (begin, move or reset)
//  output    out_valid, out_stall, out_data one status word per command
//  config    cfg_write, cfg_index, cfg_data register write, no read-back
//
// One command is taken every cycle while in_stall is low; it is written into the queue and
// its result is registered in the back part. The state update in the back part sets that
// rate, behind a four-entry queue. in_stall rises only when the queue is full, which needs
// out_stall held. After rst_n the state is standby and the registers hold their reset values.
module servo_motion_sequencer_top
    import sms_pkg::*;
#(
    parameter int MAX_ACTIONS = 255,
    parameter int TIMER_BITS  = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    q_valid;
    logic    q_pop;
    q_item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_pos     <= RST_MIN_POS;
            cfg_reg.max_pos     <= RST_MAX_POS;
            cfg_reg.loop_enable <= 1'b0;
            cfg_reg.min_delay   <= RST_MIN_DELAY;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MIN_POS:     cfg_reg.min_pos     <= cfg_data[7:0];
                CFG_MAX_POS:     cfg_reg.max_pos     <= cfg_data[7:0];
                CFG_LOOP_ENABLE: cfg_reg.loop_enable <= cfg_data[0];
                CFG_MIN_DELAY:   cfg_reg.min_delay   <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    sms_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    sms_back #(
        .MAX_ACTIONS (MAX_ACTIONS),
        .TIMER_BITS  (TIMER_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    // While running, the active action always lies inside the counted list.
    a_active_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.machine_state == ST_ACTION)
        |-> (out_data.running_action < out_data.action_total))
        else $error("active action beyond the counted list");

    // The error state is only reached with an empty list.
    a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.machine_state == ST_ERROR) |-> (out_data.action_total == 8'd0))
        else $error("error state with a non-empty list");

    // Standby always comes with cleared counters.
    a_standby_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.machine_state == ST_STANDBY)
        |-> ((out_data.action_total == 8'd0) && (out_data.running_action == 8'd0)))
        else $error("standby with counters not cleared");
`endif

endmodule

// ===== test/tb_servo_motion_sequencer_top.sv =====
// Self-checking testbench for servo_motion_sequencer_top: directed and random command streams
// are checked against a status predictor held in a small scoreboard class.
// Depends on sms_pkg and the servo_motion_sequencer_top RTL.
module tb_servo_motion_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sms_pkg::*;

    localparam int         CLK_PERIOD    = 8;
    localparam int         RESET_CYCLES  = 9;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         IDLE_PERCENT  = 29;
    localparam int         NOISE_PERCENT = 8;
    localparam int         PHASE_ITEMS   = 15;
    localparam logic [7:0] COUNT_CAP     = 8'd255;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic      cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    servo_motion_sequencer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Tracks the sequencer state and queues the status word each command should produce.
    class status_scoreboard;
        fsm_state_t  mode;
        logic [7:0]  position;
        logic [7:0]  call_idx;
        logic [7:0]  active_idx;
        logic [7:0]  action_total;
        logic [31:0] last_step;
        logic [15:0] held_delay;
        cfg_t        regs;
        out_item_t   pending[$];
        int          failures;
        int          accepted;

        function new();
            mode              = ST_STANDBY;
            position          = '0;
            call_idx          = '0;
            active_idx        = '0;
            action_total      = '0;
            last_step         = '0;
            held_delay        = '0;
            regs.min_pos      = RST_MIN_POS;
            regs.max_pos      = RST_MAX_POS;
            regs.loop_enable  = 1'b0;
            regs.min_delay    = RST_MIN_DELAY;
            failures          = 0;
            accepted          = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_MIN_POS:     regs.min_pos     = value[7:0];
                CFG_MAX_POS:     regs.max_pos     = value[7:0];
                CFG_LOOP_ENABLE: regs.loop_enable = value[0];
                CFG_MIN_DELAY:   regs.min_delay   = value;
                default: ;
            endcase
        endfunction

        function void restart_list();
            if (action_total == 8'd0)
                mode = ST_ERROR;
            else
            begin
                mode       = ST_ACTION;
                active_idx = '0;
            end
        endfunction

        function void next_action();
            if (active_idx != 8'd255)
                active_idx++;
            if (active_idx >= action_total)
            begin
                if (regs.loop_enable)
                    restart_list();
                else
                    mode = ST_HALT;
            end
            else
                mode = ST_ACTION;
        endfunction

        function void step_toward(logic [7:0] target, logic [15:0] delay, logic [31:0] stamp);
            logic [7:0]  p;
            logic [31:0] elapsed;
            held_delay = (delay < regs.min_delay) ? regs.min_delay : delay;
            // The timer is free-running, so the elapsed time wraps at 32 bits.
            elapsed = stamp - last_step;
            if (elapsed >= {16'd0, held_delay})
            begin
                last_step = stamp;
                p = (position < target) ? position + 8'd1 : position - 8'd1;
                if (p < regs.min_pos)
                    p = regs.min_pos;
                else if (p > regs.max_pos)
                    p = regs.max_pos;
                position = p;
            end
        endfunction

        function void note_command(in_item_t item);
            out_item_t status;
            accepted++;
            case (item.command)
                CMD_BEGIN:
                begin
                    call_idx = '0;
                    if (mode == ST_STANDBY)
                        mode = ST_INIT;
                    else if (mode == ST_INIT)
                        restart_list();
                end
                CMD_MOVE:
                begin
                    if (mode == ST_INIT)
                    begin
                        if (action_total < COUNT_CAP)
                            action_total++;
                    end
                    else if (mode == ST_ACTION && active_idx == call_idx)
                    begin
                        if (position == item.target_pos)
                            next_action();
                        else
                            step_toward(item.target_pos, item.step_delay, item.now);
                    end
                    if (call_idx != 8'd255)
                        call_idx++;
                end
                CMD_RESET:
                begin
                    if (mode == ST_HALT)
                    begin
                        mode         = ST_STANDBY;
                        active_idx   = '0;
                        action_total = '0;
                    end
                end
                default: ;
            endcase
            status.machine_state  = mode;
            status.position       = position;
            status.running_action = active_idx;
            status.action_total   = action_total;
            pending.push_back(status);
        endfunction

        function void check_status(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                $error("status transfer with nothing pending: %h", got);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (got.machine_state !== want.machine_state)
            begin
                $error("machine_state: expected %0d, actual %0d",
                       want.machine_state, got.machine_state);
                failures++;
            end
            if (got.position !== want.position)
            begin
                $error("position: expected %0d, actual %0d", want.position, got.position);
                failures++;
            end
            if (got.running_action !== want.running_action)
            begin
                $error("running_action: expected %0d, actual %0d",
                       want.running_action, got.running_action);
                failures++;
            end
            if (got.action_total !== want.action_total)
            begin
                $error("action_total: expected %0d, actual %0d",
                       want.action_total, got.action_total);
                failures++;
            end
        endfunction
    endclass

    status_scoreboard sb;
    logic [31:0]      ticks;
    logic [7:0]       list_target[$];
    logic [15:0]      list_delay[$];
    bit               follow_pos;
    bit               saturated;
    int               cycle_count;

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** servo_motion_sequencer_top: FAILED **");
        $finish;
    end

    // Receiver: random stalls, one long hold-off while the sender keeps offering,
    // and later a long stretch with no stalls at all.
    initial
    begin
        int hold_left;
        int calm_left;
        bit held;
        bit calmed;
        out_stall = 1'b0;
        hold_left = 0;
        calm_left = 0;
        held      = 1'b0;
        calmed    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && sb.accepted >= 150)
            begin
                held      = 1'b1;
                hold_left = 60;
            end
            if (!calmed && sb.accepted >= 500)
            begin
                calmed    = 1'b1;
                calm_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                out_stall <= 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_status(out_data);
    end

    function automatic logic [31:0] next_stamp();
        // Mostly small advances so that short delays elapse; now and then a large jump.
        if ($urandom_range(99) < 5)
            ticks = ticks + $urandom;
        else
            ticks = ticks + $urandom_range(12);
        return ticks;
    endfunction

    function automatic logic [7:0] pick_target();
        int lo;
        int hi;
        int t;
        lo = sb.regs.min_pos;
        hi = sb.regs.max_pos;
        if (lo > hi || $urandom_range(99) < 10)
            return 8'($urandom);
        t = sb.position;
        if (t < lo)
            t = lo;
        if (t > hi)
            t = hi;
        t = t + int'($urandom_range(6)) - 3;
        if (t < lo)
            t = lo;
        if (t > hi)
            t = hi;
        return 8'(t);
    endfunction

    function automatic logic [15:0] pick_delay();
        if ($urandom_range(99) < 10)
            return 16'($urandom);
        return 16'($urandom_range(8));
    endfunction

    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] tgt,
                            input logic [15:0] dly, input logic [31:0] stamp);
        in_item_t item;
        item.command    = cmd;
        item.target_pos = tgt;
        item.step_delay = dly;
        item.now        = stamp;
        // The sender never idles around the receiver's long hold-off, so the queue fills.
        while (!(sb.accepted >= 140 && sb.accepted < 330) && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_command(item);
    endtask

    task automatic send_noise();
        logic [1:0] cmd;
        cmd = 2'($urandom_range(3));
        // A begin with an empty list would trap the block in the error state for good.
        if (cmd == CMD_BEGIN && sb.mode == ST_INIT && sb.action_total == 8'd0)
            cmd = CMD_MOVE;
        send_cmd(cmd, 8'($urandom), 16'($urandom), $urandom);
    endtask

    task automatic send_listed(input logic [1:0] cmd, input logic [7:0] tgt,
                               input logic [15:0] dly);
        if ($urandom_range(99) < NOISE_PERCENT)
            send_noise();
        send_cmd(cmd, tgt, dly, next_stamp());
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic load_registers(input cfg_t c);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        put_reg(CFG_MIN_POS, {8'd0, c.min_pos});
        put_reg(CFG_MAX_POS, {8'd0, c.max_pos});
        put_reg(CFG_LOOP_ENABLE, {15'd0, c.loop_enable});
        put_reg(CFG_MIN_DELAY, c.min_delay);
        cfg_write <= 1'b0;
    endtask

    // Drives the block back to standby: finish counting, complete every action at once
    // by aiming each at the current position, then rearm from halt.
    task automatic settle_to_standby();
        while (sb.mode != ST_STANDBY && sb.mode != ST_ERROR)
        begin
            case (sb.mode)
                ST_INIT:
                begin
                    if (sb.action_total == 8'd0)
                        send_cmd(CMD_MOVE, 8'd0, 16'd0, next_stamp());
                    send_cmd(CMD_BEGIN, 8'd0, 16'd0, next_stamp());
                end
                ST_ACTION:
                begin
                    send_cmd(CMD_BEGIN, 8'd0, 16'd0, next_stamp());
                    repeat (sb.action_total) send_cmd(CMD_MOVE, sb.position, 16'd0, next_stamp());
                end
                default:
                    send_cmd(CMD_RESET, 8'd0, 16'd0, next_stamp());
            endcase
        end
    endtask

    task automatic run_sequence(input bit want_saturation);
        int n;
        int i;
        int pass;
        int pass_cap;
        case (sb.mode)
            ST_STANDBY:
            begin
                n = want_saturation ? 260 : $urandom_range(4, 1);
                if (want_saturation)
                    saturated = 1'b1;
                follow_pos = want_saturation;
                list_target.delete();
                list_delay.delete();
                for (i = 0; i < n; i++)
                begin
                    list_target.push_back(pick_target());
                    list_delay.push_back(pick_delay());
                end
                send_cmd(CMD_BEGIN, 8'($urandom), 16'($urandom), next_stamp());
                // The counting pass ignores target and delay, so they are left random.
                for (i = 0; i < n; i++)
                    send_listed(CMD_MOVE, 8'($urandom), 16'($urandom));
                send_listed(CMD_BEGIN, 8'($urandom), 16'($urandom));
            end
            ST_INIT:
            begin
                if (sb.action_total == 8'd0)
                    send_cmd(CMD_MOVE, 8'($urandom), 16'($urandom), next_stamp());
                send_cmd(CMD_BEGIN, 8'($urandom), 16'($urandom), next_stamp());
            end
            ST_HALT:
                send_cmd(CMD_RESET, 8'($urandom), 16'($urandom), next_stamp());
            default: ;
        endcase
        if (sb.mode == ST_ACTION)
        begin
            if (list_target.size() < sb.action_total)
            begin
                follow_pos = (sb.action_total > 8);
                list_target.delete();
                list_delay.delete();
                for (i = 0; i < sb.action_total; i++)
                begin
                    list_target.push_back(pick_target());
                    list_delay.push_back(pick_delay());
                end
            end
            pass_cap = (list_target.size() > 8) ? 2 : 6;
            for (pass = 0; pass < pass_cap && sb.mode == ST_ACTION; pass++)
            begin
                send_listed(CMD_BEGIN, 8'($urandom), 16'($urandom));
                for (i = 0; i < list_target.size(); i++)
                    send_listed(CMD_MOVE, follow_pos ? sb.position : list_target[i], list_delay[i]);
            end
        end
    endtask

    initial
    begin
        cfg_t plan [7];
        int   p;
        int   budget;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        ticks     = $urandom;
        saturated = 1'b0;
        follow_pos = 1'b0;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_registers(cfg_t'{RST_MIN_POS, RST_MAX_POS, 1'b0, RST_MIN_DELAY});

        // Commands outside their states, field extremes and a timer that wraps.
        send_cmd(CMD_UNUSED, 8'd255, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_RESET, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_MOVE, 8'd7, 16'd1, 32'd1);
        send_cmd(CMD_BEGIN, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_MOVE, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_MOVE, 8'd255, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_MOVE, 8'd2, 16'd0, 32'd0);
        send_cmd(CMD_UNUSED, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_RESET, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_BEGIN, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_MOVE, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_MOVE, 8'd255, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_MOVE, 8'd2, 16'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_BEGIN, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_MOVE, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_MOVE, 8'd255, 16'hFFFF, 32'd5);
        send_cmd(CMD_MOVE, 8'd2, 16'd0, 32'd5);
        send_cmd(CMD_BEGIN, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_MOVE, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_MOVE, 8'd1, 16'd0, 32'd10);
        send_cmd(CMD_MOVE, 8'd2, 16'd0, 32'd10);
        send_cmd(CMD_BEGIN, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_MOVE, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_MOVE, 8'd1, 16'd0, 32'd0);
        send_cmd(CMD_MOVE, 8'd2, 16'd0, 32'd11);
        send_cmd(CMD_RESET, 8'd0, 16'd0, 32'd0);

        plan[0] = cfg_t'{8'd0,   8'd180, 1'b0, 16'd0};
        plan[1] = cfg_t'{8'd0,   8'd255, 1'b1, 16'd0};
        plan[2] = cfg_t'{8'd20,  8'd40,  1'b0, 16'd3};
        plan[3] = cfg_t'{8'd255, 8'd255, 1'b0, 16'd0};
        plan[4] = cfg_t'{8'd100, 8'd50,  1'b0, 16'd0};
        plan[5] = cfg_t'{8'd0,   8'd0,   1'b1, 16'hFFFF};
        plan[6] = cfg_t'{8'd0,   8'd255, 1'b0, 16'd1};
        for (p = 0; p < 7; p++)
        begin
            load_registers(plan[p]);
            // The last setting starts from standby so that a full-length list can saturate.
            if (p == 6)
                settle_to_standby();
            budget = sb.accepted + PHASE_ITEMS;
            while (sb.accepted < budget || (p == 6 && !saturated))
                run_sequence(p == 6 && !saturated);
        end

        // A pass with no listed actions ends in the error state, which no command leaves.
        load_registers(cfg_t'{8'd0, 8'd255, 1'b0, 16'd0});
        settle_to_standby();
        send_cmd(CMD_BEGIN, 8'd0, 16'd0, next_stamp());
        send_cmd(CMD_BEGIN, 8'd0, 16'd0, next_stamp());
        send_cmd(CMD_MOVE, 8'd9, 16'd0, next_stamp());
        send_cmd(CMD_RESET, 8'd0, 16'd0, next_stamp());
        send_cmd(CMD_UNUSED, 8'd0, 16'd0, next_stamp());
        send_cmd(CMD_BEGIN, 8'd0, 16'd0, next_stamp());
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0)
            $display("** servo_motion_sequencer_top: PASSED **");
        else
            $display("** servo_motion_sequencer_top: FAILED **");
        $finish;
    end

endmodule
